// ===== rtl/sat_pkg.sv =====
package sat_pkg;

  // Quote mode of the scanner
  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  // Kind of one result
  typedef enum logic [1:0] {
    K_CHAR     = 2'd0,
    K_TOK_END  = 2'd1,
    K_LINE_END = 2'd2
  } kind_t;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Most results that one byte can cause
  localparam int unsigned MaxRes = 4;

endpackage

// ===== rtl/sat_if.sv =====
interface sat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_end;

  modport source (output valid, output in_byte, output line_end, input ready);
  modport sink (input valid, input in_byte, input line_end, output ready);
endinterface

interface sat_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output kind, output out_byte, output run_last, input ready);
  modport sink (input valid, input kind, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/shell_argument_tokenizer.sv =====
// Shell argument tokenizer. Takes a command line one byte per request and
// returns the argument tokens as character results, each token closed by a
// token-end result, the line closed by a line-end result; quote characters
// and escaping backslashes are removed. Each request is latched in an input
// register, then expanded into a result register of up to four entries that
// drains through the single result port, one entry a cycle while out_res.ready
// is high. Bytes that yield at most one result flow at one per cycle while
// out_res.ready is high; a byte yielding k results holds the result register
// until all k (at most four) are taken. Results are presented once their byte
// has moved from the input register into the result register.
module shell_argument_tokenizer
  import sat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  sat_in_if.sink    in_req,
  sat_out_if.source out_res
);

  // Input register
  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_last_r;

  // Scanner state
  quote_t qm_r, qm_nxt;
  logic   esc_r, esc_nxt;
  logic   held_r, held_nxt;
  logic   tok_r, tok_nxt;

  // Result register
  kind_t      ent_kind_r [MaxRes];
  logic [7:0] ent_byte_r [MaxRes];
  kind_t      ent_kind_nxt [MaxRes];
  logic [7:0] ent_byte_nxt [MaxRes];
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r;

  logic b_done, b_free, a_move;

  // Drain the result register, accept when it can take the latched byte
  assign out_res.valid    = (cnt_r != 3'd0);
  assign out_res.kind     = ent_kind_r[idx_r];
  assign out_res.out_byte = ent_byte_r[idx_r];
  assign out_res.run_last = ({1'b0, idx_r} == cnt_r - 3'd1);

  assign b_done       = out_res.valid && out_res.ready && out_res.run_last;
  assign b_free       = (cnt_r == 3'd0) || b_done;
  assign a_move       = a_valid_r && b_free;
  assign in_req.ready = !a_valid_r || a_move;

  // Expand the latched byte into its results and the next state
  always_comb begin
    logic [7:0] c;
    logic [2:0] n;
    logic       do_handle;
    c         = a_byte_r;
    n         = 3'd0;
    do_handle = 1'b1;
    qm_nxt    = qm_r;
    esc_nxt   = esc_r;
    held_nxt  = held_r;
    tok_nxt   = tok_r;
    for (int i = 0; i < MaxRes; i++) begin
      ent_kind_nxt[i] = K_CHAR;
      ent_byte_nxt[i] = CH_NUL;
    end

    // Resolve a backslash held inside double quotes
    if (held_r) begin
      held_nxt = 1'b0;
      tok_nxt  = 1'b1;
      ent_kind_nxt[n[1:0]] = K_CHAR;
      if (c == CH_DQ || c == CH_BSL) begin
        ent_byte_nxt[n[1:0]] = c;
        do_handle = 1'b0;
      end else begin
        ent_byte_nxt[n[1:0]] = CH_BSL;
      end
      n = n + 3'd1;
    end

    if (do_handle) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        tok_nxt = 1'b1;
        ent_kind_nxt[n[1:0]] = K_CHAR;
        ent_byte_nxt[n[1:0]] = c;
        n = n + 3'd1;
      end else if (c == CH_BSL && qm_r == Q_DOUBLE) begin
        held_nxt = 1'b1;
      end else if (c == CH_BSL && qm_r == Q_NONE) begin
        esc_nxt = 1'b1;
      end else if (qm_r == Q_NONE && (c == CH_SQ || c == CH_DQ)) begin
        qm_nxt = (c == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
      end else if ((qm_r == Q_SINGLE && c == CH_SQ) || (qm_r == Q_DOUBLE && c == CH_DQ) ||
                   (qm_r == Q_NONE && c == CH_NUL)) begin
        qm_nxt = Q_NONE;
      end else if (qm_r == Q_NONE && (c == CH_SP || (c >= CH_TAB && c <= CH_CR))) begin
        // Whitespace closes an open token
        if (tok_nxt) begin
          tok_nxt = 1'b0;
          ent_kind_nxt[n[1:0]] = K_TOK_END;
          ent_byte_nxt[n[1:0]] = CH_NUL;
          n = n + 3'd1;
        end
      end else begin
        tok_nxt = 1'b1;
        ent_kind_nxt[n[1:0]] = K_CHAR;
        ent_byte_nxt[n[1:0]] = c;
        n = n + 3'd1;
      end
    end

    // Close the line and return to the idle state
    if (a_last_r) begin
      if (held_nxt) begin
        tok_nxt = 1'b1;
        ent_kind_nxt[n[1:0]] = K_CHAR;
        ent_byte_nxt[n[1:0]] = CH_BSL;
        n = n + 3'd1;
      end
      if (tok_nxt) begin
        ent_kind_nxt[n[1:0]] = K_TOK_END;
        ent_byte_nxt[n[1:0]] = CH_NUL;
        n = n + 3'd1;
      end
      ent_kind_nxt[n[1:0]] = K_LINE_END;
      ent_byte_nxt[n[1:0]] = CH_NUL;
      n = n + 3'd1;
      qm_nxt   = Q_NONE;
      esc_nxt  = 1'b0;
      held_nxt = 1'b0;
      tok_nxt  = 1'b0;
    end
    cnt_nxt = n;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      a_valid_r <= in_req.valid;
    end
    if (in_req.ready && in_req.valid) begin
      a_byte_r <= in_req.in_byte;
      a_last_r <= in_req.line_end;
    end
  end

  // Scanner state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r   <= Q_NONE;
      esc_r  <= 1'b0;
      held_r <= 1'b0;
      tok_r  <= 1'b0;
      cnt_r  <= 3'd0;
      idx_r  <= 2'd0;
    end else if (a_move) begin
      qm_r   <= qm_nxt;
      esc_r  <= esc_nxt;
      held_r <= held_nxt;
      tok_r  <= tok_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= 2'd0;
    end else if (b_done) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (out_res.valid && out_res.ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      ent_kind_r <= ent_kind_nxt;
      ent_byte_r <= ent_byte_nxt;
    end
  end

  // Checks
  a_line_resets : assert property (@(posedge clk) disable iff (!rst_n)
    (a_move && a_last_r) |=> (qm_r == Q_NONE && !esc_r && !held_r && !tok_r))
    else $error("state not cleared after line end");

  a_line_end_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.kind == K_LINE_END) |-> out_res.run_last)
    else $error("line end is not the last result of its request");

  a_flags_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(esc_r && held_r))
    else $error("escape and held backslash both set");

  a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> ({1'b0, idx_r} < cnt_r))
    else $error("result index beyond count");

endmodule

// ===== dv/sat_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, predicts the token stream for every
// accepted byte and compares each returned result against it in order.
module sat_checker
  import sat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_line_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  output int         fails,
  output int         backlog,
  output int         bytes_seen,
  output int         results_seen
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } token_res_t;

  // Predicted scanner state
  quote_t     quote_st;
  logic       escape_pending;
  logic       bsl_held;
  logic       word_open;

  token_res_t token_stream_q[$];
  token_res_t step_buf [MaxRes];
  int         step_n;
  int         fail_total = 0;
  int         byte_total = 0;
  int         res_total = 0;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task emit(input kind_t k, input logic [7:0] c);
    step_buf[step_n] = '{kind: k, ch: c, last: 1'b0};
    step_n++;
  endtask

  task emit_char(input logic [7:0] c);
    word_open = 1'b1;
    emit(K_CHAR, c);
  endtask

  // Handle one byte once any held backslash has been settled
  task scan_byte(input logic [7:0] c);
    if (escape_pending) begin
      escape_pending = 1'b0;
      emit_char(c);
    end else if (c == CH_BSL) begin
      case (quote_st)
        Q_DOUBLE: bsl_held = 1'b1;
        Q_NONE:   escape_pending = 1'b1;
        default:  emit_char(c);
      endcase
    end else if (quote_st == Q_NONE && (c == CH_SQ || c == CH_DQ)) begin
      quote_st = (c == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
    end else if ((quote_st == Q_SINGLE && c == CH_SQ) ||
                 (quote_st == Q_DOUBLE && c == CH_DQ) ||
                 (quote_st == Q_NONE && c == CH_NUL)) begin
      quote_st = Q_NONE;
    end else if (quote_st == Q_NONE && is_blank(c)) begin
      if (word_open) begin
        word_open = 1'b0;
        emit(K_TOK_END, 8'h00);
      end
    end else begin
      emit_char(c);
    end
  endtask

  task clear_scanner();
    quote_st       = Q_NONE;
    escape_pending = 1'b0;
    bsl_held       = 1'b0;
    word_open      = 1'b0;
  endtask

  // Work out the results of one accepted byte and queue them
  task tokenize_byte(input logic [7:0] c, input logic last);
    step_n = 0;
    if (bsl_held) begin
      bsl_held = 1'b0;
      if (c == CH_DQ || c == CH_BSL) begin
        emit_char(c);
      end else begin
        emit_char(CH_BSL);
        scan_byte(c);
      end
    end else begin
      scan_byte(c);
    end
    if (last) begin
      if (bsl_held) emit_char(CH_BSL);
      if (word_open) emit(K_TOK_END, 8'h00);
      emit(K_LINE_END, 8'h00);
      clear_scanner();
    end
    if (step_n > 0) step_buf[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) token_stream_q = {token_stream_q, step_buf[i]};
  endtask

  always @(posedge clk) begin
    token_res_t want;
    if (!rst_n) begin
      clear_scanner();
      token_stream_q.delete();
    end else begin
      // Compare a returned result with the oldest prediction
      if (out_valid && out_ready) begin
        res_total++;
        if (token_stream_q.size() == 0) begin
          $error("unexpected result: kind %0d, out_byte %02h, run_last %0b",
                 out_kind, out_byte, out_run_last);
          fail_total++;
        end else begin
          want = token_stream_q.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
            fail_total++;
          end
          if (out_byte !== want.ch) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.ch, out_byte);
            fail_total++;
          end
          if (out_run_last !== want.last) begin
            $error("run_last mismatch: expected %0b, actual %0b", want.last, out_run_last);
            fail_total++;
          end
        end
      end
      // Predict the results of an accepted request
      if (in_valid && in_ready) begin
        byte_total++;
        tokenize_byte(in_byte, in_line_end);
      end
    end
    fails        <= fail_total;
    backlog      <= token_stream_q.size();
    bytes_seen   <= byte_total;
    results_seen <= res_total;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sat_pkg::*;

  localparam int StallLimit = 2000;

  logic       clk;
  logic       rst_n;
  logic       idling;
  int         fails;
  int         backlog;
  int         bytes_seen;
  int         results_seen;
  int         quiet_cycles = 0;
  logic [7:0] line_buf[$];

  sat_in_if  in_ch ();
  sat_out_if out_ch ();

  shell_argument_tokenizer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_res(out_ch)
  );

  sat_checker token_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_byte     (in_ch.in_byte),
    .in_line_end (in_ch.line_end),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_byte    (out_ch.out_byte),
    .out_run_last(out_ch.run_last),
    .fails       (fails),
    .backlog     (backlog),
    .bytes_seen  (bytes_seen),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result side at random while idling is on
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !(idling && $urandom_range(99) < 26);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one byte, idling first at random, and hold it until accepted
  task send_byte(input logic [7:0] c, input logic last);
    while (idling && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= c;
    in_ch.line_end <= last;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  task send_line();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  // Hold off the sender until every predicted result has come back
  task drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (backlog != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return CH_BSL;
    if (r < 22) return CH_DQ;
    if (r < 30) return CH_SQ;
    if (r < 34) return CH_NUL;
    if (r < 48) return $urandom_range(1) ? CH_SP : 8'($urandom_range(9, 13));
    if (r < 80) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int sent;
    int len;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.line_end <= 1'b0;
    idling = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Top byte, CR ends a token, unquoted NUL dropped, empty quoted span,
    // line ending on a blank
    line_buf = '{8'hFF, CH_CR, CH_NUL, 8'h61, CH_SQ, CH_SQ, CH_SP};
    send_line();
    // Escaped NUL and blank, then double quotes with escaped backslash,
    // kept backslash and a backslash still held at line end
    line_buf = '{CH_BSL, CH_NUL, CH_BSL, CH_SP, CH_DQ, CH_BSL, CH_DQ,
                 CH_BSL, CH_BSL, CH_BSL, 8'h71, CH_BSL};
    send_line();
    // Literal backslash in single quotes, trailing unquoted backslash dropped
    line_buf = '{CH_SQ, CH_BSL, CH_SQ, 8'h7A, CH_BSL};
    send_line();
    // Line ends inside open double quotes
    line_buf = '{CH_DQ, 8'h62};
    send_line();
    drain_results();

    // Random lines of mostly shell-like text
    sent = 0;
    while (sent < 134) begin
      idling = !(sent >= 50 && sent < 100);
      len = $urandom_range(1, 12);
      line_buf.delete();
      repeat (len) line_buf = {line_buf, pick_char()};
      send_line();
      sent += len;
      if (sent >= 110 && sent - len < 110) drain_results();
    end
    idling = 1'b1;
    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d command-line bytes and checked %0d tokenizer results,",
             bytes_seen, results_seen);
    $display("covering quoting, escapes, blanks, NUL and line ends under stalls.");
    if (fails == 0 && backlog == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== shell_argument_tokenizer.f =====
rtl/sat_pkg.sv
rtl/sat_if.sv
rtl/shell_argument_tokenizer.sv
dv/sat_checker.sv
dv/testbench.sv
